### rtl/mtlb_pkg.sv
// Package for the joint TLB translate block: entry count, store widths,
// operation and fault codes, state codes and the slot reduction table.
// Depends on nothing; mtlb_match and the top level use it by scoped names.
`default_nettype none

package mtlb_pkg;

    // Number of entry pairs held in the tag and page stores (2 to 32).
    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int TAG_W   = 60;
    localparam int PAGE_W  = 44;
    localparam int HALF_W  = 22;
    localparam int SLOT_IN = 64;

    typedef enum logic [1:0] {
        MODE_IDX_WRITE  = 2'd0,
        MODE_RAND_WRITE = 2'd1,
        MODE_PROBE      = 2'd2,
        MODE_TRANSLATE  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        FAULT_NONE       = 3'd0,
        FAULT_REFILL_LD  = 3'd1,
        FAULT_REFILL_ST  = 3'd2,
        FAULT_INVALID_LD = 3'd3,
        FAULT_INVALID_ST = 3'd4,
        FAULT_MODIFIED   = 3'd5
    } t_fault;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_RESULT = 2'd2
    } t_state;

    // Outcome of comparing one stored entry against the lookup key.
    typedef struct packed {
        logic        hit;
        logic [31:0] phys;
        t_fault      fault;
    } t_match;

    typedef logic [SLOT_IN-1:0][IDX_W-1:0] t_slot_tbl;

    // Write slot modulo the entry count, worked out at elaboration.
    function automatic t_slot_tbl make_slot_tbl();
        t_slot_tbl tbl;
        for (int i = 0; i < SLOT_IN; i++) begin
            tbl[i] = IDX_W'(i % ENTRIES);
        end
        return tbl;
    endfunction

    localparam t_slot_tbl SLOT_MOD = make_slot_tbl();

endpackage

`default_nettype wire

### rtl/mtlb_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read. Depends on nothing.
`default_nettype none

module mtlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/mtlb_match.sv
// Compare of one stored TLB entry against a lookup key, with page select
// and fault classification. Depends on mtlb_pkg.
`default_nettype none

module mtlb_match (
    input  wire logic [mtlb_pkg::TAG_W-1:0]  i_tag,
    input  wire logic [mtlb_pkg::PAGE_W-1:0] i_page,
    input  wire logic                        i_entry_ok,
    input  wire logic [31:0]                 i_va,
    input  wire logic [7:0]                  i_asid,
    input  wire logic                        i_is_store,
    output mtlb_pkg::t_match                 o_res
);

    logic [mtlb_pkg::TAG_W-1:0]  tag;
    logic [mtlb_pkg::PAGE_W-1:0] page;
    logic [31:0]                 mask;
    logic [31:0]                 mask2;
    logic [31:0]                 tvpn;
    logic                        vpn_eq;
    logic                        asid_ok;
    logic                        odd;
    logic [mtlb_pkg::HALF_W-1:0] half;

    // An entry never written since reset reads as all zero.
    assign tag  = i_entry_ok ? i_tag : '0;
    assign page = i_entry_ok ? i_page : '0;

    assign mask    = 32'h0000_0fff | tag[31:0];
    assign mask2   = {mask[30:0], 1'b1};
    assign tvpn    = {tag[50:32], 13'd0};
    assign vpn_eq  = (tvpn & ~mask2) == (i_va & ~mask2);
    assign asid_ok = tag[59] || (tag[58:51] == i_asid);
    assign odd     = |(i_va & (mask2 ^ mask));
    assign half    = odd ? page[43:22] : page[21:0];

    always_comb begin
        o_res.hit   = vpn_eq && asid_ok;
        o_res.phys  = 32'd0;
        o_res.fault = mtlb_pkg::FAULT_NONE;
        if (!half[20]) begin
            o_res.fault = i_is_store ? mtlb_pkg::FAULT_INVALID_ST
                                     : mtlb_pkg::FAULT_INVALID_LD;
        end else if (i_is_store && !half[21]) begin
            o_res.fault = mtlb_pkg::FAULT_MODIFIED;
        end else begin
            o_res.phys = {half[19:0], 12'd0} | (i_va & mask);
        end
    end

endmodule

`default_nettype wire

### rtl/mips_tlb_translate_top.sv
// Top level of the joint TLB: request sequencer, random pointer, wired
// register and entry valid bits. Depends on mtlb_pkg, mtlb_ram, mtlb_match.
`default_nettype none

// Usage
// The request channel (i_in_valid / o_in_stall) carries one operation per
// request, chosen by i_mode: indexed write, random write, probe or
// translate. Every request returns exactly one result on the result
// channel (o_out_valid / i_out_stall). A request is taken when valid is high
// and stall is low at a rising edge of i_clk.
// The block works on one request at a time. Writes store the entry at the
// edge that takes the request; the result then passes through the result
// state into the output register. Probe and translate read the tag and page
// stores one entry per cycle through the RAM read port and stop at the
// first match or after the last entry. The next request is taken only once
// the block is back in idle after a result is loaded.
// The result sits in an output register: a stall on the result side holds
// it and its payload, while the block goes on to take and work on the next
// request. Only when that next result is ready and the output is still
// stalled does the block wait.
// Reset (i_rst_n low, synchronous) clears the entry valid bits, so every entry
// reads as zero, sets the random pointer to ENTRIES-1 and the wired count to
// zero. i_cfg_we writes the wired count; the user must raise it only while no
// request is outstanding, and the block itself does not enforce this.

module mips_tlb_translate_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: wired count.
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    // Request channel.
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [31:0] i_entry_hi,
    input  wire logic [31:0] i_entry_lo_even,
    input  wire logic [31:0] i_entry_lo_odd,
    input  wire logic [31:0] i_page_mask_word,
    input  wire logic [5:0]  i_write_slot,
    input  wire logic [31:0] i_virt_addr,
    input  wire logic [7:0]  i_space_id,
    input  wire logic        i_is_store,
    // Result channel.
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_phys_addr,
    output logic [2:0]       o_fault,
    output logic             o_probe_hit,
    output logic [4:0]       o_probe_slot
);

    localparam int IDX_W = mtlb_pkg::IDX_W;
    localparam int CMP_W = 7;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(mtlb_pkg::ENTRIES - 1);

    // EntryLo word to a stored page half: dirty, valid, PFN.
    function automatic logic [mtlb_pkg::HALF_W-1:0] lo_half(input logic [31:0] lo);
        return {lo[2], lo[1], lo[25:6]};
    endfunction

    mtlb_pkg::t_state r_state, n_state;

    logic [IDX_W-1:0]           r_addr, n_addr;
    logic                       r_issue_done, n_issue_done;
    logic                       r_rd_pend, n_rd_pend;
    logic [IDX_W-1:0]           r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]           r_rand, n_rand;
    logic [4:0]                 r_wired;
    logic [mtlb_pkg::ENTRIES-1:0] r_valid_bits;

    // Lookup key of the request in progress.
    logic [31:0] r_key_va;
    logic [7:0]  r_key_asid;
    logic        r_is_probe;
    logic        r_store;

    // Result waiting for the output register.
    logic [31:0]      r_res_phys, n_res_phys;
    mtlb_pkg::t_fault r_res_fault, n_res_fault;
    logic             r_res_hit, n_res_hit;
    logic [4:0]       r_res_slot, n_res_slot;

    // Output register.
    logic             r_out_valid, n_out_valid;
    logic [31:0]      r_o_phys;
    mtlb_pkg::t_fault r_o_fault;
    logic             r_o_hit;
    logic [4:0]       r_o_slot;

    logic                        in_acc;
    logic                        is_write;
    logic                        out_free;
    logic                        load_out;
    logic                        ram_re;
    logic [IDX_W-1:0]            waddr;
    logic [mtlb_pkg::TAG_W-1:0]  wtag;
    logic [mtlb_pkg::PAGE_W-1:0] wpage;
    logic [mtlb_pkg::TAG_W-1:0]  rtag;
    logic [mtlb_pkg::PAGE_W-1:0] rpage;
    logic [CMP_W-1:0]            rand_dec;
    logic [IDX_W-1:0]            rand_next;
    mtlb_pkg::t_match            match;

    assign in_acc   = i_in_valid && (r_state == mtlb_pkg::ST_IDLE);
    assign is_write = (i_mode == mtlb_pkg::MODE_IDX_WRITE)
                   || (i_mode == mtlb_pkg::MODE_RAND_WRITE);
    assign out_free = !r_out_valid || !i_out_stall;

    // Write port: indexed slot or the random pointer.
    assign waddr = (i_mode == mtlb_pkg::MODE_IDX_WRITE)
                 ? mtlb_pkg::SLOT_MOD[i_write_slot] : r_rand;
    assign wtag  = {i_entry_lo_even[0] & i_entry_lo_odd[0], i_entry_hi[7:0],
                    i_entry_hi[31:13], i_page_mask_word};
    assign wpage = {lo_half(i_entry_lo_odd), lo_half(i_entry_lo_even)};

    // Random pointer steps down and wraps to the top below the wired count or past zero.
    assign rand_dec  = CMP_W'(r_rand) - CMP_W'(1);
    assign rand_next = ((r_rand == '0) || (rand_dec < CMP_W'(r_wired))
                     || (rand_dec >= CMP_W'(mtlb_pkg::ENTRIES)))
                     ? LAST_IDX : rand_dec[IDX_W-1:0];

    // Stores are written only at the edge that takes a write request and
    // read only while scanning, so a read never overlaps a write.
    mtlb_ram #(
        .WIDTH (mtlb_pkg::TAG_W),
        .DEPTH (mtlb_pkg::ENTRIES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_write),
        .i_waddr (waddr),
        .i_wdata (wtag),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (rtag)
    );

    mtlb_ram #(
        .WIDTH (mtlb_pkg::PAGE_W),
        .DEPTH (mtlb_pkg::ENTRIES)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc && is_write),
        .i_waddr (waddr),
        .i_wdata (wpage),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (rpage)
    );

    mtlb_match u_match (
        .i_tag      (rtag),
        .i_page     (rpage),
        .i_entry_ok (r_valid_bits[r_rd_idx]),
        .i_va       (r_key_va),
        .i_asid     (r_key_asid),
        .i_is_store (r_store),
        .o_res      (match)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mtlb_pkg::ST_IDLE;
            r_addr       <= '0;
            r_issue_done <= 1'b1;
            r_rd_pend    <= 1'b0;
            r_rd_idx     <= '0;
            r_rand       <= LAST_IDX;
            r_wired      <= 5'd0;
            r_valid_bits <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_addr       <= n_addr;
            r_issue_done <= n_issue_done;
            r_rd_pend    <= n_rd_pend;
            r_rd_idx     <= n_rd_idx;
            r_rand       <= n_rand;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_wired <= i_cfg_wdata;
            end
            if (in_acc && is_write) begin
                r_valid_bits[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_phys  <= n_res_phys;
        r_res_fault <= n_res_fault;
        r_res_hit   <= n_res_hit;
        r_res_slot  <= n_res_slot;
        if (in_acc) begin
            r_is_probe <= (i_mode == mtlb_pkg::MODE_PROBE);
            r_store    <= i_is_store;
            if (i_mode == mtlb_pkg::MODE_PROBE) begin
                r_key_va   <= {i_entry_hi[31:13], 13'd0};
                r_key_asid <= i_entry_hi[7:0];
            end else begin
                r_key_va   <= i_virt_addr;
                r_key_asid <= i_space_id;
            end
        end
        if (load_out) begin
            r_o_phys  <= r_res_phys;
            r_o_fault <= r_res_fault;
            r_o_hit   <= r_res_hit;
            r_o_slot  <= r_res_slot;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_issue_done = r_issue_done;
        n_rd_pend    = 1'b0;
        n_rd_idx     = r_addr;
        n_rand       = r_rand;
        n_res_phys   = r_res_phys;
        n_res_fault  = r_res_fault;
        n_res_hit    = r_res_hit;
        n_res_slot   = r_res_slot;
        n_out_valid  = r_out_valid && i_out_stall;
        load_out     = 1'b0;
        ram_re       = 1'b0;

        unique case (r_state)
            mtlb_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_res_phys  = 32'd0;
                    n_res_fault = mtlb_pkg::FAULT_NONE;
                    n_res_hit   = 1'b0;
                    n_res_slot  = 5'd0;
                    if (is_write) begin
                        n_state = mtlb_pkg::ST_RESULT;
                        if (i_mode == mtlb_pkg::MODE_RAND_WRITE) begin
                            n_rand = rand_next;
                        end
                    end else begin
                        n_state      = mtlb_pkg::ST_SCAN;
                        n_addr       = '0;
                        n_issue_done = 1'b0;
                    end
                end
            end
            mtlb_pkg::ST_SCAN: begin
                // Issue one read per cycle until the last entry is requested.
                if (!r_issue_done) begin
                    ram_re    = 1'b1;
                    n_rd_pend = 1'b1;
                    n_addr    = IDX_W'(r_addr + 1'b1);
                    if (r_addr == LAST_IDX) begin
                        n_issue_done = 1'b1;
                    end
                end
                // Evaluate the entry read in the previous cycle.
                if (r_rd_pend) begin
                    if (match.hit) begin
                        n_state      = mtlb_pkg::ST_RESULT;
                        n_rd_pend    = 1'b0;
                        n_issue_done = 1'b1;
                        if (r_is_probe) begin
                            n_res_hit  = 1'b1;
                            n_res_slot = 5'(r_rd_idx);
                        end else begin
                            n_res_phys  = match.phys;
                            n_res_fault = match.fault;
                        end
                    end else if (r_rd_idx == LAST_IDX) begin
                        n_state      = mtlb_pkg::ST_RESULT;
                        n_rd_pend    = 1'b0;
                        n_issue_done = 1'b1;
                        if (!r_is_probe) begin
                            n_res_fault = r_store ? mtlb_pkg::FAULT_REFILL_ST
                                                  : mtlb_pkg::FAULT_REFILL_LD;
                        end
                    end
                end
            end
            mtlb_pkg::ST_RESULT: begin
                if (out_free) begin
                    load_out    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = mtlb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mtlb_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_stall   = (r_state != mtlb_pkg::ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_phys_addr  = r_o_phys;
    assign o_fault      = r_o_fault;
    assign o_probe_hit  = r_o_hit;
    assign o_probe_slot = r_o_slot;

    a_write_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && is_write) |=> (r_state == mtlb_pkg::ST_RESULT))
        else $error("write request did not go straight to result");

    a_rand_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rand <= LAST_IDX)
        else $error("random pointer beyond last entry");

    a_read_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == mtlb_pkg::ST_SCAN))
        else $error("store read in flight outside scan");

    a_fault_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_o_fault != mtlb_pkg::FAULT_NONE)) |-> (r_o_phys == 32'd0))
        else $error("faulting result carries an address");

    a_probe_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_hit) |-> (r_o_fault == mtlb_pkg::FAULT_NONE))
        else $error("probe hit carries a fault");

endmodule

`default_nettype wire

### tb/tb_mips_tlb_translate_top.sv
// Self-checking testbench for the joint TLB block mips_tlb_translate_top.
// Depends on mtlb_pkg for the entry count, mode codes and fault codes; it
// drives requests, predicts every result and checks the result channel.
`timescale 1ns / 100ps

module tb_mips_tlb_translate_top;

    import mtlb_pkg::*;

    // Length of the forced result-side hold-off, in clock cycles.
    localparam int HOLD_CYCLES    = 300;
    // Requests in each random phase; seven phases make up the random part.
    localparam int PHASE_REQUESTS = 200;
    localparam int MAX_PRINTS     = 40;

    // One request as it is driven onto the request channel.
    typedef struct packed {
        t_mode       mode;
        logic [31:0] hi;
        logic [31:0] lo_even;
        logic [31:0] lo_odd;
        logic [31:0] page_mask;
        logic [5:0]  slot;
        logic [31:0] vaddr;
        logic [7:0]  asid;
        logic        store;
    } t_request;

    // One result as it appears on the result channel.
    typedef struct packed {
        logic [31:0] phys;
        t_fault      fault;
        logic        hit;
        logic [4:0]  slot;
    } t_outcome;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [4:0] cfg_wdata;
    logic       in_valid;
    t_request   cur_req;
    logic       out_stall;

    wire        o_in_stall;
    wire        o_out_valid;
    wire [31:0] o_phys_addr;
    wire [2:0]  o_fault;
    wire        o_probe_hit;
    wire [4:0]  o_probe_slot;

    mips_tlb_translate_top uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_mode          (cur_req.mode),
        .i_entry_hi      (cur_req.hi),
        .i_entry_lo_even (cur_req.lo_even),
        .i_entry_lo_odd  (cur_req.lo_odd),
        .i_page_mask_word(cur_req.page_mask),
        .i_write_slot    (cur_req.slot),
        .i_virt_addr     (cur_req.vaddr),
        .i_space_id      (cur_req.asid),
        .i_is_store      (cur_req.store),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_phys_addr     (o_phys_addr),
        .o_fault         (o_fault),
        .o_probe_hit     (o_probe_hit),
        .o_probe_slot    (o_probe_slot)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the TLB. Each entry pair keeps its tag (page mask,
    // VPN2, ASID, global bit) and, for the even and odd page, the PFN
    // with its valid and dirty bits. The random pointer and the wired
    // count live here too.
    // ------------------------------------------------------------------
    logic [31:0] pm_tbl   [ENTRIES];
    logic [18:0] vpn_tbl  [ENTRIES];
    logic [7:0]  asid_tbl [ENTRIES];
    logic        g_tbl    [ENTRIES];
    logic [19:0] pfn_tbl  [ENTRIES][2];
    logic        v_tbl    [ENTRIES][2];
    logic        d_tbl    [ENTRIES][2];
    int          rand_ptr;
    logic [4:0]  wired_shadow;

    // Results that the block still owes, oldest first.
    t_outcome    expected_results[$];
    int          mismatch_count;
    int          checked_count;

    // Idling controls: the sender's gaps and the receiver's stalls can be
    // switched off per phase to get stretches of full-rate traffic.
    logic        sender_gaps_on;
    logic        result_stalls_on;
    // Set by the stimulus, cleared by the receiver when the hold is over.
    logic        hold_req;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTS)
            $display("ERROR at %0t: result %0d, %s: got %h, expected %h",
                     $realtime, checked_count, field, got, want);
        mismatch_count++;
    endtask

    // Lowest entry whose masked VPN2 matches and whose global bit is set
    // or whose ASID matches; -1 when no entry qualifies.
    function automatic int tlb_find(input logic [31:0] va, input logic [7:0] asid);
        logic [31:0] mask;
        logic [31:0] mask2;
        for (int i = 0; i < ENTRIES; i++) begin
            mask  = 32'h0000_0fff | pm_tbl[i];
            mask2 = {mask[30:0], 1'b1};
            if ((({vpn_tbl[i], 13'b0}) & ~mask2) == (va & ~mask2) &&
                (g_tbl[i] || asid_tbl[i] == asid))
                return i;
        end
        return -1;
    endfunction

    // The entry is global only when both lo words carry the global bit.
    function automatic void store_pair(input int idx, input t_request r);
        pm_tbl[idx]     = r.page_mask;
        vpn_tbl[idx]    = r.hi[31:13];
        asid_tbl[idx]   = r.hi[7:0];
        g_tbl[idx]      = r.lo_even[0] & r.lo_odd[0];
        pfn_tbl[idx][0] = r.lo_even[25:6];
        v_tbl[idx][0]   = r.lo_even[1];
        d_tbl[idx][0]   = r.lo_even[2];
        pfn_tbl[idx][1] = r.lo_odd[25:6];
        v_tbl[idx][1]   = r.lo_odd[1];
        d_tbl[idx][1]   = r.lo_odd[2];
    endfunction

    // Applies one accepted request to the shadow TLB and returns the
    // result the block must give for it.
    function automatic t_outcome predict_request(input t_request r);
        t_outcome    res;
        int          e;
        int          cur;
        logic [31:0] mask;
        logic [31:0] mask2;
        logic        odd;
        res = '0;
        res.fault = FAULT_NONE;
        case (r.mode)
            MODE_IDX_WRITE: begin
                store_pair(r.slot % ENTRIES, r);
            end
            MODE_RAND_WRITE: begin
                // The pointer steps down and wraps to the top once it
                // would drop below the wired count or past entry zero.
                cur = rand_ptr;
                if (cur == 0 || cur - 1 < wired_shadow)
                    rand_ptr = ENTRIES - 1;
                else
                    rand_ptr = cur - 1;
                store_pair(cur, r);
            end
            MODE_PROBE: begin
                e = tlb_find({r.hi[31:13], 13'b0}, r.hi[7:0]);
                if (e >= 0) begin
                    res.hit  = 1'b1;
                    res.slot = e[4:0];
                end
            end
            default: begin
                e = tlb_find(r.vaddr, r.asid);
                if (e < 0) begin
                    res.fault = r.store ? FAULT_REFILL_ST : FAULT_REFILL_LD;
                end else begin
                    // The page is odd when the address has the bit just
                    // above the mask set; irregular masks follow the same rule.
                    mask  = 32'h0000_0fff | pm_tbl[e];
                    mask2 = {mask[30:0], 1'b1};
                    odd   = |(r.vaddr & (mask2 ^ mask));
                    if (!v_tbl[e][odd])
                        res.fault = r.store ? FAULT_INVALID_ST : FAULT_INVALID_LD;
                    else if (r.store && !d_tbl[e][odd])
                        res.fault = FAULT_MODIFIED;
                    else
                        res.phys = {pfn_tbl[e][odd], 12'b0} | (r.vaddr & mask);
                end
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checker and predictor, both at the rising edge. A result leaves the
    // block when valid is high and our stall is low; a request enters when
    // our valid is high and the block's stall is low. Results are checked
    // before the new request is predicted, so the order is fixed.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_checker
        t_outcome want;
        if (rst_n) begin
            if (o_out_valid === 1'b1 && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request waiting", o_phys_addr, '0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_phys_addr !== want.phys)
                        report_mismatch("phys_addr", o_phys_addr, want.phys);
                    if (o_fault !== want.fault)
                        report_mismatch("fault", 32'(o_fault), 32'(want.fault));
                    if (o_probe_hit !== want.hit)
                        report_mismatch("probe_hit", 32'(o_probe_hit), 32'(want.hit));
                    if (o_probe_slot !== want.slot)
                        report_mismatch("probe_slot", 32'(o_probe_slot), 32'(want.slot));
                    checked_count++;
                end
            end
            if (cfg_we)
                wired_shadow = cfg_wdata;
            if (in_valid && o_in_stall === 1'b0)
                expected_results.push_back(predict_request(cur_req));
        end
    end

    // ------------------------------------------------------------------
    // Result side. Stalls come in runs of random length, usually the shortest
    // kind, now and then a long one. A hold-off request forces the stall high
    // until the count held here reaches HOLD_CYCLES, and is then cleared.
    // ------------------------------------------------------------------
    initial begin : result_receiver
        int stall_left;
        int free_left;
        int held;
        int pick;
        stall_left = 0;
        free_left  = 0;
        held       = 0;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_stall <= 1'b1;
                held++;
                if (held == HOLD_CYCLES) begin
                    hold_req = 1'b0;
                    held     = 0;
                end
            end else if (!result_stalls_on) begin
                out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else if (free_left > 0) begin
                out_stall <= 1'b0;
                free_left--;
            end else begin
                out_stall <= 1'b0;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    stall_left = $urandom_range(1, 2);
                else if (pick < 95)
                    stall_left = $urandom_range(3, 8);
                else
                    stall_left = $urandom_range(20, 60);
                pick = $urandom_range(0, 99);
                if (pick < 50)
                    free_left = $urandom_range(0, 2);
                else if (pick < 90)
                    free_left = $urandom_range(3, 10);
                else
                    free_left = $urandom_range(15, 40);
            end
        end
    end

    // Idle cycles before the next request: mostly none, a few long ones.
    function automatic int pick_gap();
        int pick;
        if (!sender_gaps_on)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Offers one request and returns at the falling edge after it was taken.
    // Valid stays high when the next request follows without a gap, so the
    // caller must either send again or call wait_for_results.
    task automatic send_request(input t_request r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cur_req  <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (o_in_stall !== 1'b0);
        @(negedge clk);
    endtask

    // Stops offering requests and waits until every result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    // The wired count may change only while no request is outstanding.
    task automatic set_wired(input logic [4:0] value);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic t_request pack_request(
        input t_mode m, input logic [31:0] hi, input logic [31:0] lo0,
        input logic [31:0] lo1, input logic [31:0] pm, input logic [5:0] slot,
        input logic [31:0] va, input logic [7:0] asid, input logic st);
        t_request r;
        r = '{m, hi, lo0, lo1, pm, slot, va, asid, st};
        return r;
    endfunction

    // Random request with random content in every field. Writes favor a
    // small set of VPN2 and ASID values and the architectural page masks,
    // so entries overlap. Most lookups are aimed at a stored entry so that
    // hits, the odd/even choice and every fault kind come up often.
    function automatic t_request make_random_request();
        t_request    r;
        int          pick;
        int          j;
        logic [31:0] m;
        logic [31:0] m2;
        r.hi        = $urandom;
        r.lo_even   = $urandom;
        r.lo_odd    = $urandom;
        r.page_mask = $urandom;
        r.slot      = 6'($urandom_range(0, 63));
        r.vaddr     = $urandom;
        r.asid      = 8'($urandom_range(0, 255));
        r.store     = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            r.mode = (pick < 20) ? MODE_IDX_WRITE : MODE_RAND_WRITE;
            if ($urandom_range(0, 1))
                r.hi[31:13] = 19'($urandom_range(0, 7));
            if ($urandom_range(0, 3) != 0)
                r.hi[7:0] = 8'($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 50)
                r.page_mask = '0;
            else if (pick < 90)
                r.page_mask = ((32'd1 << (2 * $urandom_range(1, 8))) - 1) << 13;
            r.lo_even[1] = ($urandom_range(0, 4) != 0);
            r.lo_odd[1]  = ($urandom_range(0, 4) != 0);
        end else begin
            r.mode = (pick < 50) ? MODE_PROBE : MODE_TRANSLATE;
            if ($urandom_range(0, 3) != 0) begin
                j  = $urandom_range(0, ENTRIES - 1);
                m  = 32'h0000_0fff | pm_tbl[j];
                m2 = {m[30:0], 1'b1};
                r.vaddr = ({vpn_tbl[j], 13'b0} & ~m2) | (r.vaddr & m2);
                if (!g_tbl[j] || $urandom_range(0, 1))
                    r.asid = asid_tbl[j];
                r.hi = {r.vaddr[31:13], r.hi[12:8], r.asid};
            end
        end
        return r;
    endfunction

    // After reset every entry has VPN2 0, ASID 0 and is invalid.
    task automatic test_reset_contents();
        send_request(pack_request(MODE_PROBE, 32'h0000_0000, '0, '0, '0, '0, '0, '0, 1'b0));
        send_request(pack_request(MODE_PROBE, 32'h0000_0001, '0, '0, '0, '0, '0, '0, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h0000_1abc, 8'h00, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h0000_0000, 8'h00, 1'b1));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h0000_2000, 8'h00, 1'b1));
    endtask

    // Every operation and fault kind, the field extremes, the global bit
    // taken from both lo words, an irregular mask and the largest mask.
    task automatic test_operations();
        // Slot 63 lands on the top entry; all-ones words give a global,
        // valid and dirty pair that maps all ones to all ones.
        send_request(pack_request(MODE_IDX_WRITE, '1, '1, '1, '0, 6'd63, '0, '0, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0, '1, 8'h00, 1'b1));
        // Slot 32 wraps to entry 0. Only the odd lo word has the global
        // bit, so the entry is not global; the odd page is invalid.
        send_request(pack_request(MODE_IDX_WRITE, 32'h0000_4005, 32'h0000_1046,
                                  32'h0000_0081, '0, 6'd32, '0, '0, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h0000_4123, 8'h05, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h0000_5123, 8'h05, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h0000_5123, 8'h05, 1'b1));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h0000_4123, 8'h06, 1'b0));
        send_request(pack_request(MODE_PROBE, 32'h0000_4005, '0, '0, '0, '0, '0, '0, 1'b0));
        // Global entry whose even page is clean: a store faults as modified.
        send_request(pack_request(MODE_IDX_WRITE, 32'h0000_8007, 32'h0000_0003,
                                  32'h03ff_ffc7, '0, 6'd1, '0, '0, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h0000_8010, 8'h99, 1'b1));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h0000_9fff, 8'h12, 1'b1));
        // Irregular page mask with a hole in it.
        send_request(pack_request(MODE_IDX_WRITE, 32'h1234_0003, 32'h0123_4567,
                                  32'h02ab_cde6, 32'h0000_5000, 6'd2, '0, '0, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h1234_3abc, 8'h03, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h1234_babc, 8'h03, 1'b0));
        // Random writes at the top of the pointer range.
        send_request(pack_request(MODE_RAND_WRITE, 32'h0040_0000, 32'h0000_0046,
                                  32'h0000_0046, '0, '0, '0, '0, 1'b0));
        send_request(pack_request(MODE_RAND_WRITE, 32'h0060_0002, 32'h0000_0086,
                                  32'h0000_0006, '0, '0, '0, '0, 1'b0));
        send_request(pack_request(MODE_PROBE, 32'h0060_0002, '0, '0, '0, '0, '0, '0, 1'b0));
        // Largest architectural mask.
        send_request(pack_request(MODE_IDX_WRITE, 32'h4000_0009, 32'h0155_5547,
                                  32'h02aa_aa87, 32'h1fff_e000, 6'd3, '0, '0, 1'b0));
        send_request(pack_request(MODE_TRANSLATE, '0, '0, '0, '0, '0,
                                  32'h7fff_fff0, 8'h09, 1'b1));
        send_request(pack_request(MODE_PROBE, 32'hffff_e0ff, '0, '0, '0, '0, '0, '0, 1'b0));
    endtask

    // Random writes under the wired extremes, a value close to the top and one
    // in the middle, so the pointer wraps on the wired limit and past entry zero.
    task automatic test_wired_wrap();
        t_request r;
        logic [4:0] settings [4];
        int counts [4];
        settings = '{5'd31, 5'd28, 5'd0, 5'd17};
        counts   = '{4, 8, 40, 20};
        for (int s = 0; s < 4; s++) begin
            set_wired(settings[s]);
            for (int n = 0; n < counts[s]; n++) begin
                r = make_random_request();
                r.mode = MODE_RAND_WRITE;
                send_request(r);
            end
            r = make_random_request();
            r.mode = MODE_PROBE;
            send_request(r);
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while requests keep
    // coming, so the block fills up and stalls the request channel.
    task automatic test_result_hold_off();
        t_request r;
        wait_for_results();
        sender_gaps_on = 1'b0;
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
        for (int n = 0; n < 12; n++) begin
            r = make_random_request();
            if (n % 2 == 0)
                r.mode = MODE_TRANSLATE;
            send_request(r);
        end
        wait_for_results();
    endtask

    // Phases of random traffic, each under its own wired count and idle
    // pattern. The first phase runs flat out on both sides; each phase
    // ends with the sender waiting until every result has arrived.
    task automatic test_random_traffic();
        for (int p = 0; p < 7; p++) begin
            set_wired(5'($urandom_range(0, 31)));
            sender_gaps_on   = (p != 0) && ($urandom_range(0, 3) != 0);
            result_stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_REQUESTS; n++)
                send_request(make_random_request());
            wait_for_results();
        end
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            pm_tbl[i]   = '0;
            vpn_tbl[i]  = '0;
            asid_tbl[i] = '0;
            g_tbl[i]    = 1'b0;
            for (int k = 0; k < 2; k++) begin
                pfn_tbl[i][k] = '0;
                v_tbl[i][k]   = 1'b0;
                d_tbl[i][k]   = 1'b0;
            end
        end
        rand_ptr         = ENTRIES - 1;
        wired_shadow     = '0;
        mismatch_count   = 0;
        checked_count    = 0;
        hold_req         = 1'b0;
        sender_gaps_on   = 1'b1;
        result_stalls_on = 1'b1;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_valid         = 1'b0;
        cur_req          = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_contents();
        test_operations();
        test_wired_wrap();
        test_result_hold_off();
        test_random_traffic();

        // Let a full scan's worth of cycles pass so a stray extra result
        // would still be caught.
        wait_for_results();
        repeat (ENTRIES + 10) @(negedge clk);
        if (mismatch_count == 0)
            $display("mips_tlb_translate_top: match");
        else
            $display("mips_tlb_translate_top: mismatch");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #15_000_000;
        $display("mips_tlb_translate_top: mismatch");
        $finish;
    end

endmodule
